FILE: src/tra_pkg.sv
// Shared types, codes and constants for the tagged ring allocator.
// No dependencies; every other file refers to it by scoped names.
package tra_pkg;

	localparam int unsigned MAX_REGION_BYTES = 65536;
	localparam int unsigned POS_W            = 17;
	localparam int unsigned TAG_W            = 8;
	localparam int unsigned OFS_W            = 32;
	localparam int unsigned OVH_W            = 8;
	localparam int unsigned ADDR_W           = 16;
	localparam int unsigned MIN_REGION_BYTES = 16;
	localparam int unsigned HDR_BYTES        = 2;

	typedef enum logic [1:0] {
		CMD_ALLOC   = 2'd0,
		CMD_RECLAIM = 2'd1,
		CMD_BREAK   = 2'd2
	} cmd_t;

	typedef enum logic {
		CFG_REGION   = 1'b0,
		CFG_OVERHEAD = 1'b1
	} cfg_idx_t;

	typedef struct packed {
		logic [POS_W-1:0] region_bytes;
		logic [OVH_W-1:0] space_overhead;
	} cfg_t;

	typedef struct packed {
		logic [1:0]              cmd;
		logic [POS_W-1:0]        req_bytes;
		logic [TAG_W-1:0]        chunk_tag_in;
		logic signed [OFS_W-1:0] first_offset;
		logic signed [OFS_W-1:0] last_offset;
		logic                    report_offset;
		logic [POS_W-1:0]        reclaim_bytes;
	} item_t;

	typedef struct packed {
		logic                    ok;
		logic [ADDR_W-1:0]       data_offset;
		logic                    header_written;
		logic                    wrapped;
		logic [ADDR_W-1:0]       end_marker_offset;
		logic signed [OFS_W-1:0] prev_offset;
		logic [POS_W-1:0]        free_space;
	} result_t;

endpackage

FILE: src/tra_cfg.sv
// Configuration register file of the tagged ring allocator.
// Depends on tra_pkg for the register index codes and the cfg_t struct.
module tra_cfg (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        wr_en,
	input  logic                        wr_index,
	input  logic [tra_pkg::POS_W-1:0]   wr_data,
	output tra_pkg::cfg_t               cfg
);

	tra_pkg::cfg_t cfg_q;

	// Take a register write beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.region_bytes   <= tra_pkg::POS_W'(tra_pkg::MAX_REGION_BYTES);
			cfg_q.space_overhead <= tra_pkg::OVH_W'(4);
		end else if (wr_en) begin
			case (tra_pkg::cfg_idx_t'(wr_index))
				tra_pkg::CFG_REGION:   cfg_q.region_bytes   <= wr_data;
				tra_pkg::CFG_OVERHEAD: cfg_q.space_overhead <= wr_data[tra_pkg::OVH_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

FILE: src/tra_core.sv
// Allocator state and the combinational next-state and result logic.
// Depends on tra_pkg for item, result and configuration types.
module tra_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  tra_pkg::item_t    item,
	input  tra_pkg::cfg_t     cfg,
	output tra_pkg::result_t  res
);

	localparam int unsigned PW = tra_pkg::POS_W;

	logic [PW-1:0]                    alloc_pos_q, reclaim_pos_q, wrap_limit_q;
	logic [tra_pkg::TAG_W-1:0]        open_tag_q;
	logic signed [tra_pkg::OFS_W-1:0] open_ofs_q;
	logic                             chunk_open_q;

	logic [PW-1:0]                    alloc_pos_d, reclaim_pos_d, wrap_limit_d;
	logic [tra_pkg::TAG_W-1:0]        open_tag_d;
	logic signed [tra_pkg::OFS_W-1:0] open_ofs_d;
	logic                             chunk_open_d;

	logic [PW-1:0]  region_eff;
	logic           need_hdr;
	logic [PW:0]    size_a, size_w, after, rec_sum;
	logic           blocked;
	logic           fits;
	logic signed [PW+1:0] room, space;

	// Clamp the region size into its legal range
	always_comb begin
		region_eff = cfg.region_bytes;
		if (cfg.region_bytes < PW'(tra_pkg::MIN_REGION_BYTES))
			region_eff = PW'(tra_pkg::MIN_REGION_BYTES);
		else if (cfg.region_bytes > PW'(tra_pkg::MAX_REGION_BYTES))
			region_eff = PW'(tra_pkg::MAX_REGION_BYTES);
	end

	// Header decision and placement arithmetic
	always_comb begin
		need_hdr = (open_tag_q != item.chunk_tag_in) || (open_ofs_q > item.first_offset)
			|| !chunk_open_q;
		size_a = {1'b0, item.req_bytes} + (need_hdr ? (PW+1)'(tra_pkg::HDR_BYTES) : '0);
		after  = {1'b0, alloc_pos_q} + size_a;
		// a wrapped allocation always carries a header
		size_w = need_hdr ? size_a : size_a + (PW+1)'(tra_pkg::HDR_BYTES);
		blocked = (wrap_limit_q != '0) && ((reclaim_pos_q == alloc_pos_q)
			|| ((reclaim_pos_q > alloc_pos_q) && ({1'b0, reclaim_pos_q} < after)));
		fits    = after < {1'b0, region_eff};
		rec_sum = {1'b0, reclaim_pos_q} + {1'b0, item.reclaim_bytes};
	end

	// Next state and result fields
	always_comb begin
		alloc_pos_d   = alloc_pos_q;
		reclaim_pos_d = reclaim_pos_q;
		wrap_limit_d  = wrap_limit_q;
		open_tag_d    = open_tag_q;
		open_ofs_d    = open_ofs_q;
		chunk_open_d  = chunk_open_q;
		res           = '0;
		case (tra_pkg::cmd_t'(item.cmd))
			tra_pkg::CMD_ALLOC: begin
				if (!blocked && fits) begin
					res.ok          = 1'b1;
					res.data_offset = alloc_pos_q[tra_pkg::ADDR_W-1:0];
					if (need_hdr) begin
						open_tag_d         = item.chunk_tag_in;
						open_ofs_d         = '0;
						chunk_open_d       = 1'b1;
						res.header_written = 1'b1;
						res.data_offset    = alloc_pos_q[tra_pkg::ADDR_W-1:0]
							+ tra_pkg::ADDR_W'(tra_pkg::HDR_BYTES);
					end
					alloc_pos_d = after[PW-1:0];
				end else if (!blocked && ({1'b0, reclaim_pos_q} >= size_w)) begin
					res.ok                = 1'b1;
					res.wrapped           = 1'b1;
					res.header_written    = 1'b1;
					res.end_marker_offset = alloc_pos_q[tra_pkg::ADDR_W-1:0];
					res.data_offset       = tra_pkg::ADDR_W'(tra_pkg::HDR_BYTES);
					wrap_limit_d          = alloc_pos_q;
					open_tag_d            = item.chunk_tag_in;
					open_ofs_d            = '0;
					chunk_open_d          = 1'b1;
					alloc_pos_d           = size_w[PW-1:0];
				end
				if (res.ok && item.report_offset) begin
					res.prev_offset = open_ofs_d;
					open_ofs_d      = item.last_offset;
				end
			end
			tra_pkg::CMD_RECLAIM: begin
				if (wrap_limit_q != '0) begin
					if (rec_sum >= {1'b0, wrap_limit_q}) begin
						reclaim_pos_d = '0;
						wrap_limit_d  = '0;
					end else begin
						reclaim_pos_d = rec_sum[PW-1:0];
					end
				end else begin
					reclaim_pos_d = (rec_sum > {1'b0, alloc_pos_q}) ? alloc_pos_q
						: rec_sum[PW-1:0];
				end
			end
			tra_pkg::CMD_BREAK: chunk_open_d = 1'b0;
			default: ;
		endcase

		// Free space estimate from the updated positions, floored at zero
		if (wrap_limit_d != '0)
			room = $signed({2'b00, reclaim_pos_d}) - $signed({2'b00, alloc_pos_d});
		else begin
			room = $signed({2'b00, region_eff}) - $signed({2'b00, alloc_pos_d})
				- (PW+2)'(1);
			if (room < $signed({2'b00, reclaim_pos_d}))
				room = $signed({2'b00, reclaim_pos_d});
		end
		space = room - $signed({(PW+2-tra_pkg::OVH_W)'(0), cfg.space_overhead});
		res.free_space = space[PW+1] ? '0 : space[PW-1:0];
	end

	// Commit state on each step
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alloc_pos_q   <= '0;
			reclaim_pos_q <= '0;
			wrap_limit_q  <= '0;
			open_tag_q    <= '0;
			open_ofs_q    <= '0;
			chunk_open_q  <= 1'b0;
		end else if (step) begin
			alloc_pos_q   <= alloc_pos_d;
			reclaim_pos_q <= reclaim_pos_d;
			wrap_limit_q  <= wrap_limit_d;
			open_tag_q    <= open_tag_d;
			open_ofs_q    <= open_ofs_d;
			chunk_open_q  <= chunk_open_d;
		end
	end

endmodule

FILE: src/tagged_ring_allocator_top.sv
// Tagged ring allocator: bump allocation over a circular byte region with
// an input register, combinational allocator logic and a result register.
// Depends on tra_pkg, tra_cfg and tra_core.
//
// One item is accepted every clock cycle while in_stall is low. Its result
// passes the input register, then the result register, before it is offered.
// The rate is set by the allocator state update in tra_core, which reads and
// writes the ring positions for each item it takes. While the result register
// holds a stalled beat the input register still takes one more item.
// Configuration writes are always ready and should be issued only while the
// allocator is idle.
module tagged_ring_allocator_top (
	input  logic                               clk,
	input  logic                               arst_n,
	// configuration write channel
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic                               cfg_index,
	input  logic [tra_pkg::POS_W-1:0]          cfg_data,
	// item channel
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic [1:0]                         cmd,
	input  logic [tra_pkg::POS_W-1:0]          req_bytes,
	input  logic [tra_pkg::TAG_W-1:0]          chunk_tag_in,
	input  logic signed [tra_pkg::OFS_W-1:0]   first_offset,
	input  logic signed [tra_pkg::OFS_W-1:0]   last_offset,
	input  logic                               report_offset,
	input  logic [tra_pkg::POS_W-1:0]          reclaim_bytes,
	// result channel
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic                               ok,
	output logic [tra_pkg::ADDR_W-1:0]         data_offset,
	output logic                               header_written,
	output logic                               wrapped,
	output logic [tra_pkg::ADDR_W-1:0]         end_marker_offset,
	output logic signed [tra_pkg::OFS_W-1:0]   prev_offset,
	output logic [tra_pkg::POS_W-1:0]          free_space
);

	tra_pkg::cfg_t    cfg;
	tra_pkg::item_t   item_s1;
	tra_pkg::result_t res_c;
	tra_pkg::result_t res_s2;
	logic             valid_s1, valid_s2;
	logic             advance, take;

	assign cfg_ready = 1'b1;

	tra_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	// Move a beat from the input register when the result register frees up
	assign advance  = valid_s1 && (!valid_s2 || !out_stall);
	assign in_stall = valid_s1 && !advance;
	assign take     = in_valid && !in_stall;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (take || advance)
			valid_s1 <= take;
	end

	always_ff @(posedge clk) begin
		if (take) begin
			item_s1.cmd           <= cmd;
			item_s1.req_bytes     <= req_bytes;
			item_s1.chunk_tag_in  <= chunk_tag_in;
			item_s1.first_offset  <= first_offset;
			item_s1.last_offset   <= last_offset;
			item_s1.report_offset <= report_offset;
			item_s1.reclaim_bytes <= reclaim_bytes;
		end
	end

	tra_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.item   (item_s1),
		.cfg    (cfg),
		.res    (res_c)
	);

	// Result register: hold while stalled
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s2 <= 1'b0;
		else if (!valid_s2 || !out_stall)
			valid_s2 <= advance;
	end

	always_ff @(posedge clk) begin
		if (advance)
			res_s2 <= res_c;
	end

	assign out_valid         = valid_s2;
	assign ok                = res_s2.ok;
	assign data_offset       = res_s2.data_offset;
	assign header_written    = res_s2.header_written;
	assign wrapped           = res_s2.wrapped;
	assign end_marker_offset = res_s2.end_marker_offset;
	assign prev_offset       = res_s2.prev_offset;
	assign free_space        = res_s2.free_space;

endmodule

FILE: src/tra_checker.sv
// Port-level checks for the tagged ring allocator, bound to the top level.
// Depends on tra_pkg for field widths and the header size.
module tra_checker (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               out_valid,
	input  logic                               out_stall,
	input  logic                               ok,
	input  logic [tra_pkg::ADDR_W-1:0]         data_offset,
	input  logic                               header_written,
	input  logic                               wrapped,
	input  logic [tra_pkg::ADDR_W-1:0]         end_marker_offset,
	input  logic signed [tra_pkg::OFS_W-1:0]   prev_offset,
	input  logic [tra_pkg::POS_W-1:0]          free_space
);

	// A stalled result beat stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result beat dropped while stalled");

	// A stalled result beat keeps its ok flag, data offset, free space and previous offset
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(ok) && $stable(data_offset)
			&& $stable(free_space) && $stable(prev_offset))
		else $error("result payload changed while stalled");

	// A refused or non-allocate result carries only the free space
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !ok |-> data_offset == '0 && !header_written && !wrapped
			&& end_marker_offset == '0 && prev_offset == '0)
		else $error("failed result has stray fields");

	// A wrap restarts at zero behind a fresh header
	a_wrap_hdr: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && wrapped |-> ok && header_written
			&& data_offset == tra_pkg::ADDR_W'(tra_pkg::HDR_BYTES))
		else $error("wrap without header at start of region");

	// A header always sits in front of the data
	a_hdr_room: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && header_written |-> ok
			&& data_offset >= tra_pkg::ADDR_W'(tra_pkg::HDR_BYTES))
		else $error("header placed without room before data");

endmodule

bind tagged_ring_allocator_top tra_checker u_tra_checker (.*);
